### rtl/core/pnrs_pkg.sv
// Shared types and constants for the packet number range set.
package pnrs_pkg;

  localparam int NUM_CELLS = 16;
  localparam int IDX_W     = 4;
  localparam int COUNT_W   = 5;
  localparam int PN_W      = 62;
  localparam int STATUS_W  = 2;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EXT_DN,
    OP_EXT_UP,
    OP_MERGE,
    OP_INSERT
  } op_t;

  // Broadcast from control to every cell.
  typedef struct packed {
    logic            cmp_en;
    op_t             op;
    logic [PN_W-1:0] pn;
    logic [PN_W-1:0] pn_p1;
    logic [PN_W-1:0] pn_m1;
  } bcast_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic [PN_W-1:0] lo;
    logic [PN_W-1:0] hi;
    logic            above;
  } link_t;

  // Per-cell match flags back to control.
  typedef struct packed {
    logic dup;
    logic ext_dn;
    logic ext_up;
  } flags_t;

endpackage

### rtl/core/packet_number_range_set.sv
// Top level of the packet number range set: control, cell chain and result register.
//
//   channel   direction  handshake           payload
//   input     in         start / busy        in_func, in_packet_number, in_range_index
//   result    out        out_valid strobe    out_status, out_range_low, out_range_high,
//                                            out_range_valid, out_range_count
//
// Each beat has a compare step, where every cell compares its range with the
// packet number, and then an update step, where the cells shift, extend or merge together.
// busy is high only in the compare cycle; the next beat is taken as the update lands.
// The result is registered at the end of the update step and stays for one cycle.
// Reset empties the table; the receiver cannot stall.
module packet_number_range_set (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [pnrs_pkg::PN_W-1:0]       in_packet_number,
  input  logic [pnrs_pkg::IDX_W-1:0]      in_range_index,
  output logic                            out_valid,
  output logic [pnrs_pkg::STATUS_W-1:0]   out_status,
  output logic [pnrs_pkg::PN_W-1:0]       out_range_low,
  output logic [pnrs_pkg::PN_W-1:0]       out_range_high,
  output logic                            out_range_valid,
  output logic [pnrs_pkg::COUNT_W-1:0]    out_range_count
);

  pnrs_pkg::state_t state_r, state_nxt;
  logic                          func_r, func_nxt;
  logic [pnrs_pkg::PN_W-1:0]     pn_r, pn_nxt;
  logic [pnrs_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [pnrs_pkg::COUNT_W-1:0]  count_r, count_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [pnrs_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [pnrs_pkg::PN_W-1:0]     out_low_r, out_low_nxt;
  logic [pnrs_pkg::PN_W-1:0]     out_high_r, out_high_nxt;
  logic                          out_rvalid_r, out_rvalid_nxt;
  logic [pnrs_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  pnrs_pkg::bcast_t  bc;
  pnrs_pkg::link_t   links [pnrs_pkg::NUM_CELLS];
  pnrs_pkg::flags_t  flags [pnrs_pkg::NUM_CELLS];
  logic [pnrs_pkg::NUM_CELLS-1:0] held;
  logic [pnrs_pkg::NUM_CELLS-1:0] dup_vec, extdn_vec, extup_vec;
  logic accept;
  logic any_dup, any_dn, any_up, full;

  assign busy   = (state_r == pnrs_pkg::S_CMP);
  assign accept = start && !busy;

  genvar k;
  generate
    for (k = 0; k < pnrs_pkg::NUM_CELLS; k++) begin : g_cell
      pnrs_pkg::link_t left_l, right_l;
      assign held[k]      = (pnrs_pkg::COUNT_W'(k) < count_r);
      assign dup_vec[k]   = flags[k].dup;
      assign extdn_vec[k] = flags[k].ext_dn;
      assign extup_vec[k] = flags[k].ext_up;
      if (k == 0) begin : g_first
        assign left_l = '{lo: '0, hi: '0, above: 1'b1};
      end else begin : g_mid
        assign left_l = links[k-1];
      end
      if (k == pnrs_pkg::NUM_CELLS - 1) begin : g_last
        assign right_l = '{lo: '0, hi: '0, above: 1'b0};
      end else begin : g_inner
        assign right_l = links[k+1];
      end
      pnrs_cell u_cell (
        .clk   (clk),
        .bc    (bc),
        .held  (held[k]),
        .left  (left_l),
        .right (right_l),
        .self  (links[k]),
        .flags (flags[k])
      );
    end
  endgenerate

  assign any_dup = |dup_vec;
  assign any_dn  = |extdn_vec;
  assign any_up  = |extup_vec;
  assign full    = (count_r == pnrs_pkg::COUNT_W'(pnrs_pkg::NUM_CELLS));

  always_comb begin
    bc.cmp_en = (state_r == pnrs_pkg::S_CMP);
    bc.pn     = pn_r;
    bc.pn_p1  = pn_r + pnrs_pkg::PN_W'(1);
    bc.pn_m1  = pn_r - pnrs_pkg::PN_W'(1);
    bc.op     = pnrs_pkg::OP_NONE;
    if (state_r == pnrs_pkg::S_UPD && func_r == pnrs_pkg::FUNC_ADD && !any_dup) begin
      if (any_dn && any_up) begin
        bc.op = pnrs_pkg::OP_MERGE;
      end else if (any_dn) begin
        bc.op = pnrs_pkg::OP_EXT_DN;
      end else if (any_up) begin
        bc.op = pnrs_pkg::OP_EXT_UP;
      end else if (!full) begin
        bc.op = pnrs_pkg::OP_INSERT;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    pn_nxt         = pn_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = pnrs_pkg::ST_OK;
    out_low_nxt    = '0;
    out_high_nxt   = '0;
    out_rvalid_nxt = 1'b0;
    out_count_nxt  = out_count_r;

    case (bc.op)
      pnrs_pkg::OP_MERGE:  count_nxt = count_r - pnrs_pkg::COUNT_W'(1);
      pnrs_pkg::OP_INSERT: count_nxt = count_r + pnrs_pkg::COUNT_W'(1);
      default:             count_nxt = count_r;
    endcase

    case (state_r)
      pnrs_pkg::S_IDLE: begin
        if (accept) state_nxt = pnrs_pkg::S_CMP;
      end
      pnrs_pkg::S_CMP: begin
        state_nxt = pnrs_pkg::S_UPD;
      end
      pnrs_pkg::S_UPD: begin
        state_nxt     = accept ? pnrs_pkg::S_CMP : pnrs_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
        out_count_nxt = count_nxt;
        if (func_r == pnrs_pkg::FUNC_ADD) begin
          if (any_dup) begin
            out_status_nxt = pnrs_pkg::ST_DUP;
          end else if (!any_dn && !any_up && full) begin
            out_status_nxt = pnrs_pkg::ST_FULL;
          end
        end else if (held[idx_r]) begin
          out_low_nxt    = links[idx_r].lo;
          out_high_nxt   = links[idx_r].hi;
          out_rvalid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = pnrs_pkg::S_IDLE;
      end
    endcase

    if (accept) begin
      func_nxt = in_func;
      pn_nxt   = in_packet_number;
      idx_nxt  = in_range_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pnrs_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    pn_r         <= pn_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_low_r    <= out_low_nxt;
    out_high_r   <= out_high_nxt;
    out_rvalid_r <= out_rvalid_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_range_low   = out_low_r;
  assign out_range_high  = out_high_r;
  assign out_range_valid = out_rvalid_r;
  assign out_range_count = out_count_r;

endmodule

### rtl/core/pnrs_cell.sv
// One table slot: holds a range, compares it against the beat, shifts with its neighbors.
module pnrs_cell (
  input  logic            clk,
  input  pnrs_pkg::bcast_t bc,
  input  logic            held,
  input  pnrs_pkg::link_t left,
  input  pnrs_pkg::link_t right,
  output pnrs_pkg::link_t self,
  output pnrs_pkg::flags_t flags
);

  logic [pnrs_pkg::PN_W-1:0] lo_r, lo_nxt;
  logic [pnrs_pkg::PN_W-1:0] hi_r, hi_nxt;
  logic above_r, above_nxt;
  logic dup_r, dup_nxt;
  logic lodn_r, lodn_nxt;
  logic hiup_r, hiup_nxt;
  logic firstpos;
  logic lastabove;

  assign firstpos  = !above_r && left.above;
  assign lastabove = above_r && !right.above;

  assign self.lo    = lo_r;
  assign self.hi    = hi_r;
  assign self.above = above_r;

  assign flags.dup    = dup_r;
  assign flags.ext_dn = lastabove && lodn_r;
  assign flags.ext_up = held && firstpos && hiup_r;

  always_comb begin
    above_nxt = above_r;
    dup_nxt   = dup_r;
    lodn_nxt  = lodn_r;
    hiup_nxt  = hiup_r;
    if (bc.cmp_en) begin
      above_nxt = held && (bc.pn <= hi_r);
      dup_nxt   = held && (bc.pn <= hi_r) && (bc.pn >= lo_r);
      lodn_nxt  = (lo_r == bc.pn_p1);
      hiup_nxt  = (hi_r == bc.pn_m1);
    end
  end

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    case (bc.op)
      pnrs_pkg::OP_EXT_DN: begin
        if (lastabove) lo_nxt = bc.pn;
      end
      pnrs_pkg::OP_EXT_UP: begin
        if (held && firstpos) hi_nxt = bc.pn;
      end
      pnrs_pkg::OP_MERGE: begin
        if (lastabove) begin
          lo_nxt = right.lo;
        end else if (!above_r) begin
          lo_nxt = right.lo;
          hi_nxt = right.hi;
        end
      end
      pnrs_pkg::OP_INSERT: begin
        if (firstpos) begin
          lo_nxt = bc.pn;
          hi_nxt = bc.pn;
        end else if (!above_r) begin
          lo_nxt = left.lo;
          hi_nxt = left.hi;
        end
      end
      default: begin
        lo_nxt = lo_r;
        hi_nxt = hi_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    above_r <= above_nxt;
    dup_r   <= dup_nxt;
    lodn_r  <= lodn_nxt;
    hiup_r  <= hiup_nxt;
  end

endmodule

### verif/testbench.sv
// Testbench for packet_number_range_set: directed and random add and read beats against a range table model.
module testbench;

  localparam logic [pnrs_pkg::PN_W-1:0] PN_MAX = '1;
  localparam int TARGET_BEATS = 1550;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic [pnrs_pkg::STATUS_W-1:0] status;
    logic [pnrs_pkg::PN_W-1:0]     range_low;
    logic [pnrs_pkg::PN_W-1:0]     range_high;
    logic                          range_valid;
    logic [pnrs_pkg::COUNT_W-1:0]  range_count;
  } range_result_t;

  class range_set_scoreboard;
    logic [pnrs_pkg::PN_W-1:0] low_b[pnrs_pkg::NUM_CELLS];
    logic [pnrs_pkg::PN_W-1:0] high_b[pnrs_pkg::NUM_CELLS];
    int                        held;
    range_result_t             expected_results[$];
    int unsigned               mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function logic [pnrs_pkg::STATUS_W-1:0] add_number(logic [pnrs_pkg::PN_W-1:0] pn);
      int  n;
      int  i;
      int  k;
      bit  has_above;
      bit  has_below;
      bit  ext_dn;
      bit  ext_up;
      n = held;
      i = 0;
      while (i < n && pn <= high_b[i]) begin
        if (pn >= low_b[i])
          return pnrs_pkg::ST_DUP;
        i++;
      end
      has_above = (i > 0);
      has_below = (i < n);
      ext_dn = has_above && (low_b[i-1] - pnrs_pkg::PN_W'(1) == pn);
      ext_up = has_below && (high_b[i] + pnrs_pkg::PN_W'(1) == pn);
      if (ext_dn || ext_up) begin
        if (ext_dn)
          low_b[i-1] = pn;
        else
          high_b[i] = pn;
        if (has_above && has_below && (low_b[i-1] - pnrs_pkg::PN_W'(1) == high_b[i])) begin
          low_b[i-1] = low_b[i];
          for (k = i; k + 1 < n; k++) begin
            low_b[k]  = low_b[k+1];
            high_b[k] = high_b[k+1];
          end
          n--;
        end
      end else begin
        if (n >= pnrs_pkg::NUM_CELLS)
          return pnrs_pkg::ST_FULL;
        for (k = n; k > i; k--) begin
          low_b[k]  = low_b[k-1];
          high_b[k] = high_b[k-1];
        end
        low_b[i]  = pn;
        high_b[i] = pn;
        n++;
      end
      held = n;
      return pnrs_pkg::ST_OK;
    endfunction

    function void note_beat(logic func, logic [pnrs_pkg::PN_W-1:0] pn,
                            logic [pnrs_pkg::IDX_W-1:0] idx);
      range_result_t r;
      r.status      = pnrs_pkg::ST_OK;
      r.range_low   = '0;
      r.range_high  = '0;
      r.range_valid = 1'b0;
      if (func == pnrs_pkg::FUNC_ADD) begin
        r.status = add_number(pn);
      end else if (int'(idx) < held) begin
        r.range_low   = low_b[idx];
        r.range_high  = high_b[idx];
        r.range_valid = 1'b1;
      end
      r.range_count = held[pnrs_pkg::COUNT_W-1:0];
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [pnrs_pkg::STATUS_W-1:0] st,
                               logic [pnrs_pkg::PN_W-1:0] lo,
                               logic [pnrs_pkg::PN_W-1:0] hi, logic valid,
                               logic [pnrs_pkg::COUNT_W-1:0] cnt);
      range_result_t e;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
        return;
      end
      e = expected_results.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        mismatches++;
      end
      if (lo !== e.range_low) begin
        $error("range_low: expected %0h, actual %0h", e.range_low, lo);
        mismatches++;
      end
      if (hi !== e.range_high) begin
        $error("range_high: expected %0h, actual %0h", e.range_high, hi);
        mismatches++;
      end
      if (valid !== e.range_valid) begin
        $error("range_valid: expected %0d, actual %0d", e.range_valid, valid);
        mismatches++;
      end
      if (cnt !== e.range_count) begin
        $error("range_count: expected %0d, actual %0d", e.range_count, cnt);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic                          in_func;
  logic [pnrs_pkg::PN_W-1:0]     in_packet_number;
  logic [pnrs_pkg::IDX_W-1:0]    in_range_index;
  logic                          out_valid;
  logic [pnrs_pkg::STATUS_W-1:0] out_status;
  logic [pnrs_pkg::PN_W-1:0]     out_range_low;
  logic [pnrs_pkg::PN_W-1:0]     out_range_high;
  logic                          out_range_valid;
  logic [pnrs_pkg::COUNT_W-1:0]  out_range_count;

  range_set_scoreboard sb;
  int                  beats_sent;
  int                  cycles;

  packet_number_range_set u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_packet_number (in_packet_number),
    .in_range_index   (in_range_index),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_range_low    (out_range_low),
    .out_range_high   (out_range_high),
    .out_range_valid  (out_range_valid),
    .out_range_count  (out_range_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_beat(in_func, in_packet_number, in_range_index);
    if (rst_n && out_valid)
      sb.check_result(out_status, out_range_low, out_range_high, out_range_valid,
                      out_range_count);
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [pnrs_pkg::PN_W-1:0] rand_pn();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[pnrs_pkg::PN_W-1:0];
  endfunction

  function automatic logic [pnrs_pkg::IDX_W-1:0] rand_idx();
    return pnrs_pkg::IDX_W'($urandom_range(0, 15));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_beat(logic func, logic [pnrs_pkg::PN_W-1:0] pn,
                           logic [pnrs_pkg::IDX_W-1:0] idx, int gap);
    start            <= 1'b1;
    in_func          <= func;
    in_packet_number <= pn;
    in_range_index   <= idx;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    beats_sent++;
    if (gap > 0) begin
      start            <= 1'b0;
      in_func          <= 1'($urandom_range(0, 1));
      in_packet_number <= rand_pn();
      in_range_index   <= rand_idx();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_pn(logic [pnrs_pkg::PN_W-1:0] pn);
    send_beat(pnrs_pkg::FUNC_ADD, pn, rand_idx(), pick_gap());
  endtask

  task automatic read_at(logic [pnrs_pkg::IDX_W-1:0] idx);
    send_beat(pnrs_pkg::FUNC_READ, rand_pn(), idx, pick_gap());
  endtask

  task automatic run_directed();
    read_at(4'd0);
    read_at(4'd15);
    add_pn('0);
    add_pn(PN_MAX);
    add_pn('0);
    add_pn(62'd1);
    add_pn(PN_MAX - pnrs_pkg::PN_W'(1));
    add_pn(62'd3);
    add_pn(62'd2);
    add_pn(62'd1000);
    add_pn(62'd998);
    add_pn(62'd999);
    add_pn(62'd997);
    add_pn(PN_MAX);
    read_at(4'd0);
    read_at(4'd1);
    read_at(4'd2);
    read_at(4'd3);
    read_at(4'd15);
  endtask

  task automatic run_window();
    int                        width;
    int                        count;
    int                        j;
    int                        r;
    int                        gap;
    bit                        sparse;
    bit                        quiet;
    logic [pnrs_pkg::PN_W-1:0] base;
    logic [pnrs_pkg::PN_W-1:0] pn;
    case ($urandom_range(0, 2))
      0: width = 8;
      1: width = 40;
      default: width = 120;
    endcase
    sparse = ($urandom_range(0, 3) == 0);
    quiet  = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 7))
      0: base = '0;
      1: base = PN_MAX - pnrs_pkg::PN_W'(width);
      default: begin
        base = rand_pn();
        if (base > PN_MAX - pnrs_pkg::PN_W'(width))
          base = PN_MAX - pnrs_pkg::PN_W'(width);
      end
    endcase
    count = $urandom_range(16, 60);
    for (j = 0; j < count; j++) begin
      gap = quiet ? 0 : pick_gap();
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_beat(pnrs_pkg::FUNC_READ, rand_pn(), rand_idx(), gap);
      end else if (r < 20) begin
        send_beat(pnrs_pkg::FUNC_ADD, rand_pn(), rand_idx(), gap);
      end else begin
        if (sparse)
          pn = base + pnrs_pkg::PN_W'(2 * $urandom_range(0, width / 2 - 1));
        else
          pn = base + pnrs_pkg::PN_W'($urandom_range(0, width - 1));
        send_beat(pnrs_pkg::FUNC_ADD, pn, rand_idx(), gap);
      end
    end
  endtask

  initial begin
    sb = new();
    beats_sent = 0;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_func          <= pnrs_pkg::FUNC_ADD;
    in_packet_number <= '0;
    in_range_index   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    while (beats_sent < TARGET_BEATS)
      run_window();
    start <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
